// ===== rtl/core/ddalr_pkg.sv =====
// ddalr_pkg: shared types and constants for the DDA line rasterizer.
// No dependencies.
package ddalr_pkg;

	localparam int COORD_BITS_DEF = 12;

	// request kinds carried on the input tuser
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_NEXT = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
	} axis_ctl_t;

endpackage

// ===== rtl/core/ddalr_axis.sv =====
// ddalr_axis: one coordinate axis of the rasterizer; holds base, magnitude,
// direction and error accumulator. Depends on ddalr_pkg.
module ddalr_axis import ddalr_pkg::*; #(
	parameter int CB = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  axis_ctl_t     ctl,
	input  logic [CB-1:0] pt_start,
	input  logic [CB-1:0] pt_end,
	input  logic [CB-1:0] major,
	output logic [CB-1:0] mag_d,
	output logic [CB-1:0] pixel
);

	logic          neg_d;
	logic [CB-1:0] base_q;
	logic [CB-1:0] mag_q;
	logic          neg_q;
	logic [CB-1:0] err_q;
	logic [CB:0]   sum;
	logic          wrap;
	logic [CB-1:0] err_nx;
	logic [CB-1:0] base_nx;

	assign neg_d = (pt_end < pt_start);
	assign mag_d = neg_d ? (pt_start - pt_end) : (pt_end - pt_start);

	// negative direction: floor of a non-integer sits one below base
	assign pixel = (neg_q && (err_q != '0)) ? (base_q - 1'b1) : base_q;

	assign sum    = {1'b0, err_q} + {1'b0, mag_q};
	assign wrap   = (sum >= {1'b0, major});
	assign err_nx = wrap ? CB'(sum - {1'b0, major}) : sum[CB-1:0];
	always_comb begin
		base_nx = base_q;
		if (wrap) begin
			base_nx = neg_q ? (base_q - 1'b1) : (base_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			mag_q  <= '0;
			neg_q  <= 1'b0;
			err_q  <= '0;
		end else if (ctl.load) begin
			base_q <= pt_start;
			mag_q  <= mag_d;
			neg_q  <= neg_d;
			err_q  <= '0;
		end else if (ctl.step) begin
			base_q <= base_nx;
			err_q  <= err_nx;
		end
	end

endmodule

// ===== rtl/core/dda_line_rasterizer_core.sv =====
// dda_line_rasterizer_core: top level of the DDA line rasterizer.
// A next-pixel request is registered in the input stage, then its pixel in the output register.
// Throughput: one request per cycle, one pixel per cycle; stalls only while the
// output register holds a pixel that is not taken.
// Reset: arst_n clears the control and line state (data registers are not reset); no line pending, output idle.
// Depends on ddalr_pkg and ddalr_axis.
module dda_line_rasterizer_core import ddalr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// x_start, y_start, x_end, y_end
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	// req_type
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// pixel_x, pixel_y
	output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
	output logic                                   m_axis_tlast
);

	localparam int CB    = COORD_BITS;
	localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

	logic          valid_s1;
	logic          req_s1;
	logic [CB-1:0] xs_s1, ys_s1, xe_s1, ye_s1;

	logic [CB-1:0] major_q;
	logic [CB-1:0] left_q;
	logic [CB-1:0] major_d;
	logic [CB-1:0] mag_x_d, mag_y_d;
	logic [CB-1:0] pix_x, pix_y;

	logic          out_valid_q;
	logic [CB-1:0] px_q, py_q;
	logic          last_q;

	logic          out_free;
	logic          is_load;
	logic          emit;
	logic          consume;
	axis_ctl_t     ctl;

	assign out_free = !out_valid_q || m_axis_tready;
	assign is_load  = valid_s1 && (req_s1 == REQ_LOAD);
	assign emit     = valid_s1 && (req_s1 == REQ_NEXT) && (left_q != '0) && out_free;
	assign consume  = is_load || emit || (valid_s1 && (left_q == '0));
	assign s_axis_tready = !valid_s1 || consume;

	assign ctl.load = is_load;
	assign ctl.step = emit;

	assign major_d = (mag_x_d > mag_y_d) ? mag_x_d : mag_y_d;

	ddalr_axis #(.CB(CB)) u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pt_start (xs_s1),
		.pt_end   (xe_s1),
		.major    (major_q),
		.mag_d    (mag_x_d),
		.pixel    (pix_x)
	);

	ddalr_axis #(.CB(CB)) u_axis_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pt_start (ys_s1),
		.pt_end   (ye_s1),
		.major    (major_q),
		.mag_d    (mag_y_d),
		.pixel    (pix_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			major_q     <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (is_load) begin
				major_q <= major_d;
				left_q  <= major_d;
			end else if (emit) begin
				left_q <= left_q - 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1 <= s_axis_tuser;
			xs_s1  <= s_axis_tdata[CB-1:0];
			ys_s1  <= s_axis_tdata[2*CB-1:CB];
			xe_s1  <= s_axis_tdata[3*CB-1:2*CB];
			ye_s1  <= s_axis_tdata[4*CB-1:3*CB];
		end
		if (emit) begin
			px_q   <= pix_x;
			py_q   <= pix_y;
			last_q <= (left_q == CB'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({py_q, px_q});
	assign m_axis_tlast  = last_q;

endmodule

// ===== rtl/core/ddalr_checker.sv =====
// ddalr_checker: port-level assertions for dda_line_rasterizer_core, bound
// to the top level. Depends on ddalr_pkg.
module ddalr_checker import ddalr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input logic                              s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic                              m_axis_tlast
);

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	// input only backs up behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a fresh pixel comes from an earlier next-pixel transfer
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_NEXT), 2))
		else $error("pixel without a matching request");

	// a load transfer never yields a pixel
	a_load_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD) |=> ##1
			!$rose(m_axis_tvalid))
		else $error("load transfer produced a pixel");

endmodule

bind dda_line_rasterizer_core ddalr_checker #(.COORD_BITS(COORD_BITS)) u_ddalr_checker (.*);

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for dda_line_rasterizer_core.
// Drives load and next-pixel transfers and checks every emitted pixel
// against a built-in line stepper. Depends on ddalr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top import ddalr_pkg::*;;

	localparam int CB = COORD_BITS_DEF;
	localparam int CMAX = (1 << CB) - 1;
	localparam int IW = ((4*CB+7)/8)*8;
	localparam int OW = ((2*CB+7)/8)*8;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic          kind;
		logic [CB-1:0] xs, ys, xe, ye;
		bit            drain;
		bit            stall;
	} line_req_t;

	typedef struct packed {
		logic [CB-1:0] px;
		logic [CB-1:0] py;
		logic          last;
	} pixel_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic [IW-1:0] s_axis_tdata = '0;
	logic          s_axis_tuser = REQ_NEXT;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [OW-1:0] m_axis_tdata;
	logic          m_axis_tlast;

	dda_line_rasterizer_core #(.COORD_BITS(CB)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	line_req_t req_q[$];
	pixel_t    pixel_q[$];
	int        errors = 0;
	int        counted = 0;
	int unsigned cyc = 0;
	int        idle_cyc = 0;
	logic      in_fire = 1'b0;
	int        gap_left = 0;
	int        rx_gap = 0;
	int        rx_hold_cnt = 0;
	int        rx_hold_reqs = 0;
	int        rx_hold_seen = 0;
	line_req_t cur;
	wire       quiet = ((cyc / 400) % 4) == 3;

	// line stepper state
	logic [CB-1:0] pos_x = '0, pos_y = '0;
	logic [CB-1:0] mag_x = '0, mag_y = '0;
	logic          neg_x = 1'b0, neg_y = 1'b0;
	logic [CB-1:0] span = '0;
	logic [CB-1:0] err_x = '0, err_y = '0;
	logic [CB-1:0] remaining = '0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clampc(int v);
		if (v < 0) return 0;
		if (v > CMAX) return CMAX;
		return v;
	endfunction

	task automatic rasterize(input line_req_t r);
		pixel_t        p;
		logic [CB:0]   sx, sy;
		if (r.kind == REQ_LOAD) begin
			neg_x = r.xe < r.xs;
			neg_y = r.ye < r.ys;
			mag_x = neg_x ? r.xs - r.xe : r.xe - r.xs;
			mag_y = neg_y ? r.ys - r.ye : r.ye - r.ys;
			span = (mag_x > mag_y) ? mag_x : mag_y;
			pos_x = r.xs;
			pos_y = r.ys;
			err_x = '0;
			err_y = '0;
			remaining = span;
		end else if (remaining != 0) begin
			// floor, one below the position, when stepping down with a fraction
			p.px = (neg_x && err_x != 0) ? pos_x - 1'b1 : pos_x;
			p.py = (neg_y && err_y != 0) ? pos_y - 1'b1 : pos_y;
			p.last = (remaining == 1);
			pixel_q.push_back(p);
			sx = err_x + mag_x;
			if (sx >= span) begin
				sx = sx - span;
				pos_x = neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
			end
			err_x = sx[CB-1:0];
			sy = err_y + mag_y;
			if (sy >= span) begin
				sy = sy - span;
				pos_y = neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
			end
			err_y = sy[CB-1:0];
			remaining = remaining - 1'b1;
		end
	endtask

	task automatic push_req(input logic kind, input int xs, ys, xe, ye,
			input bit drain, input bit stall);
		line_req_t r;
		r.kind = kind;
		r.xs = xs[CB-1:0];
		r.ys = ys[CB-1:0];
		r.xe = xe[CB-1:0];
		r.ye = ye[CB-1:0];
		r.drain = drain;
		r.stall = stall;
		req_q.push_back(r);
	endtask

	// load followed by n next-pixel requests
	task automatic line_seq(input int xs, ys, xe, ye, n, input bit drain, input bit stall);
		int len, adx, ady;
		adx = (xe > xs) ? xe - xs : xs - xe;
		ady = (ye > ys) ? ye - ys : ys - ye;
		len = (adx > ady) ? adx : ady;
		push_req(REQ_LOAD, xs, ys, xe, ye, drain, stall);
		for (int i = 0; i < n; i++)
			push_req(REQ_NEXT, $urandom_range(0, CMAX), $urandom_range(0, CMAX),
				$urandom_range(0, CMAX), $urandom_range(0, CMAX), 1'b0, 1'b0);
		counted += 1 + ((n < len) ? n : len);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (req_q.size() != 0 && !(req_q[0].drain && pixel_q.size() != 0)) begin
				cur = req_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= cur.kind;
				s_axis_tdata <= IW'({cur.ye, cur.xe, cur.ys, cur.xs});
				gap_left <= quiet ? 0 : pick_gap();
				if (cur.stall)
					rx_hold_reqs <= rx_hold_reqs + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold_cnt != 0) begin
			rx_hold_cnt <= rx_hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_hold_seen != rx_hold_reqs) begin
			rx_hold_seen <= rx_hold_reqs;
			rx_hold_cnt <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				rx_gap <= pick_gap();
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		line_req_t seen;
		pixel_t    want;
		cyc <= cyc + 1;
		in_fire <= s_axis_tvalid && s_axis_tready && arst_n;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time,
						m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB], m_axis_tlast);
					errors++;
				end else begin
					want = pixel_q.pop_front();
					if (m_axis_tdata[CB-1:0] !== want.px) begin
						$display("%0t: pixel_x expected %0d got %0d", $time, want.px,
							m_axis_tdata[CB-1:0]);
						errors++;
					end
					if (m_axis_tdata[2*CB-1:CB] !== want.py) begin
						$display("%0t: pixel_y expected %0d got %0d", $time, want.py,
							m_axis_tdata[2*CB-1:CB]);
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$display("%0t: last_pixel expected %0b got %0b", $time, want.last,
							m_axis_tlast);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				seen.kind = s_axis_tuser;
				seen.xs = s_axis_tdata[CB-1:0];
				seen.ys = s_axis_tdata[2*CB-1:CB];
				seen.xe = s_axis_tdata[3*CB-1:2*CB];
				seen.ye = s_axis_tdata[4*CB-1:3*CB];
				seen.drain = 1'b0;
				seen.stall = 1'b0;
				rasterize(seen);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cyc <= 0;
			else
				idle_cyc <= idle_cyc + 1;
			if (idle_cyc >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cyc);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int seq, r, sel, reach, xs, ys, xe, ye, len, n;
		bit drain;

		// directed lines
		push_req(REQ_NEXT, CMAX, CMAX, CMAX, CMAX, 1'b0, 1'b0);
		line_seq(CMAX, CMAX, 0, 0, 3, 1'b0, 1'b0);
		line_seq(0, 0, CMAX, 1, 3, 1'b0, 1'b0);
		line_seq(CMAX, 0, CMAX, 0, 1, 1'b1, 1'b0);
		line_seq(10, 10, 3, 5, 8, 1'b0, 1'b0);
		line_seq(0, CMAX, 2, CMAX, 2, 1'b0, 1'b0);

		seq = 0;
		while (counted < 1600) begin
			seq++;
			r = $urandom_range(0, 99);
			if (seq == 30 || seq == 120) begin
				// long line while the output is held off
				line_seq(100, 200, 180, 150, 80, 1'b0, 1'b1);
			end else if (r < 8) begin
				push_req(1'($urandom_range(0, 1)), $urandom_range(0, CMAX),
					$urandom_range(0, CMAX), $urandom_range(0, CMAX),
					$urandom_range(0, CMAX), 1'b0, 1'b0);
				counted++;
			end else begin
				sel = $urandom_range(0, 99);
				reach = (sel < 70) ? 12 : (sel < 92) ? 100 : CMAX;
				xs = $urandom_range(0, CMAX);
				ys = $urandom_range(0, CMAX);
				xe = clampc(xs + $urandom_range(0, 2*reach) - reach);
				ye = clampc(ys + $urandom_range(0, 2*reach) - reach);
				len = (xe > xs) ? xe - xs : xs - xe;
				len = ((ye > ys ? ye - ys : ys - ye) > len) ? (ye > ys ? ye - ys : ys - ye) : len;
				sel = $urandom_range(0, 99);
				if (sel < 70)
					n = len;
				else if (sel < 85)
					n = len + $urandom_range(1, 3);
				else
					n = $urandom_range(0, len);
				if (n > 150)
					n = $urandom_range(0, 150);
				drain = (seq == 31 || seq == 121 || seq % 50 == 0);
				line_seq(xs, ys, xe, ye, n, drain, 1'b0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (req_q.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (pixel_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
